[rtl/core/ddm_pkg.sv]
package ddm_pkg;

  localparam logic signed [7:0] CMD_LIMIT = 8'sd100;
  localparam logic signed [7:0] DEAD_BAND = 8'sd10;
  localparam logic [6:0]        SIDE_MIN  = 7'd10;

  localparam logic [3:0] BITS_OFF    = 4'h0;
  localparam logic [3:0] BITS_FWD    = 4'h5;
  localparam logic [3:0] BITS_REV    = 4'hA;
  localparam logic [3:0] BITS_SPIN_L = 4'h6;
  localparam logic [3:0] BITS_SPIN_R = 4'h9;

  localparam logic [11:0] CMP_MIN   = 12'd1000;
  localparam logic [11:0] CMP_STEP  = 12'd30;
  localparam logic [11:0] CMP_LIMIT = 12'd3900;

  localparam logic [26:0] RECIP_100   = 27'd5243;
  localparam int          RECIP_SHIFT = 19;

  localparam logic [1:0] QDEPTH = 2'd2;

  typedef enum logic {
    KIND_HOLD,
    KIND_MIX
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [3:0]         bits;
    logic               fwd;
    logic signed [7:0]  speed;
    logic [6:0]         mag;
    logic [6:0]         steer_mag;
    logic               steer_left;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_APPLY,
    ST_WAIT
  } back_state_t;

endpackage

[rtl/core/ddm_in_if.sv]
interface ddm_in_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] speed;
  logic signed [7:0] steer;
  logic              obstacle_near;

  modport source (output valid, output speed, output steer, output obstacle_near, input ready);
  modport sink (input valid, input speed, input steer, input obstacle_near, output ready);
endinterface

[rtl/core/ddm_out_if.sv]
interface ddm_out_if;
  logic              valid;
  logic              ready;
  logic [3:0]        direction_bits;
  logic [11:0]       left_compare;
  logic [11:0]       right_compare;
  logic              heading_forward;
  logic signed [7:0] stored_speed;

  modport source (output valid, output direction_bits, output left_compare,
                  output right_compare, output heading_forward, output stored_speed,
                  input ready);
  modport sink (input valid, input direction_bits, input left_compare,
                input right_compare, input heading_forward, input stored_speed,
                output ready);
endinterface

[rtl/core/ddm_front.sv]
module ddm_front (
  ddm_in_if.sink       in_ch,
  input  logic         mode,
  output ddm_pkg::cmd_t cmd,
  output logic         cmd_valid,
  input  logic         cmd_ready
);
  import ddm_pkg::*;

  logic signed [7:0] sp_c;
  logic signed [7:0] st_c;
  logic signed [7:0] sp_neg;
  logic signed [7:0] st_neg;
  logic              p_dead;
  logic              p_neg;
  logic              b_dead;
  logic              b_fwd;
  logic [3:0]        b_bits;

  assign cmd_valid   = in_ch.valid;
  assign in_ch.ready = cmd_ready;

  assign sp_c = (in_ch.speed < -CMD_LIMIT) ? -CMD_LIMIT :
                (in_ch.speed > CMD_LIMIT) ? CMD_LIMIT : in_ch.speed;
  assign st_c = (in_ch.steer < -CMD_LIMIT) ? -CMD_LIMIT :
                (in_ch.steer > CMD_LIMIT) ? CMD_LIMIT : in_ch.steer;
  assign sp_neg = -sp_c;
  assign st_neg = -st_c;

  assign p_dead = (sp_c > -DEAD_BAND) && (sp_c < DEAD_BAND);
  assign p_neg  = sp_c < 8'sd0;
  assign b_dead = (in_ch.speed > -DEAD_BAND) && (in_ch.speed < DEAD_BAND);
  assign b_fwd  = in_ch.speed > 8'sd0;

  always_comb begin
    if (in_ch.steer < -DEAD_BAND) begin
      b_bits = b_fwd ? BITS_SPIN_L : BITS_SPIN_R;
    end else if (in_ch.steer > DEAD_BAND) begin
      b_bits = b_fwd ? BITS_SPIN_R : BITS_SPIN_L;
    end else begin
      b_bits = b_fwd ? BITS_FWD : BITS_REV;
    end
  end

  always_comb begin
    cmd.mag        = p_neg ? sp_neg[6:0] : sp_c[6:0];
    cmd.steer_mag  = (st_c < 8'sd0) ? st_neg[6:0] : st_c[6:0];
    cmd.steer_left = st_c < 8'sd0;
    if (mode) begin
      cmd.kind  = KIND_HOLD;
      cmd.speed = in_ch.speed;
      cmd.fwd   = !b_dead && b_fwd;
      cmd.bits  = (b_dead || (b_fwd && in_ch.obstacle_near)) ? BITS_OFF : b_bits;
    end else begin
      cmd.speed = sp_c;
      cmd.fwd   = !p_dead && !p_neg;
      if (p_dead || (!p_neg && in_ch.obstacle_near)) begin
        cmd.kind = KIND_HOLD;
        cmd.bits = BITS_OFF;
      end else begin
        cmd.kind = KIND_MIX;
        cmd.bits = p_neg ? BITS_REV : BITS_FWD;
      end
    end
  end

endmodule

[rtl/core/ddm_queue.sv]
module ddm_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  ddm_pkg::cmd_t push_data,
  input  logic          push_valid,
  output logic          push_ready,
  output ddm_pkg::cmd_t pop_data,
  output logic          pop_valid,
  input  logic          pop_ready
);
  import ddm_pkg::*;

  cmd_t       head_r, head_nxt;
  cmd_t       tail_r, tail_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  logic       pop;

  assign push_ready = count_r != QDEPTH;
  assign pop_valid  = count_r != 2'd0;
  assign pop_data   = head_r;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r + 2'(push) - 2'(pop);
    if (push && ((count_r == 2'd0) || ((count_r == 2'd1) && pop))) begin
      head_nxt = push_data;
    end else if (pop && (count_r == QDEPTH)) begin
      head_nxt = tail_r;
    end
    if (push && (((count_r == 2'd1) && !pop) || ((count_r == QDEPTH) && pop))) begin
      tail_nxt = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QDEPTH) else $error("queue count overflow");

  a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push && (count_r == 2'd1)) |=> !pop_valid) else $error("queue not empty after drain");

  a_fill_head: assert property (@(posedge clk) disable iff (!rst_n)
    (push && (count_r == 2'd0)) |=> (pop_valid && (head_r == $past(push_data))))
    else $error("queue head lost request");
`endif

endmodule

[rtl/core/ddm_back.sv]
module ddm_back (
  input  logic          clk,
  input  logic          rst_n,
  input  ddm_pkg::cmd_t q_data,
  input  logic          q_valid,
  output logic          q_ready,
  ddm_out_if.source     out_ch
);
  import ddm_pkg::*;

  back_state_t       state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [13:0]       prod_r, prod_nxt;
  logic [6:0]        quot_r, quot_nxt;
  logic [3:0]        bridge_r, bridge_nxt;
  logic [11:0]       lcmp_r, lcmp_nxt;
  logic [11:0]       rcmp_r, rcmp_nxt;
  logic              fwd_r, fwd_nxt;
  logic signed [7:0] spd_r, spd_nxt;
  logic [26:0]       q_full;
  logic [6:0]        scaled;
  logic [6:0]        left_side;
  logic [6:0]        right_side;
  logic              take;

  function automatic logic [11:0] side_compare(input logic [6:0] side);
    logic [11:0] c;
    c = CMP_MIN + CMP_STEP * 12'(side);
    return (c >= CMP_LIMIT) ? CMP_LIMIT : c;
  endfunction

  assign q_full     = 27'(prod_r) * RECIP_100;
  assign scaled     = cmd_r.mag - quot_r;
  assign left_side  = cmd_r.steer_left ? scaled : cmd_r.mag;
  assign right_side = cmd_r.steer_left ? cmd_r.mag : scaled;

  assign out_ch.valid           = state_r == ST_WAIT;
  assign out_ch.direction_bits  = bridge_r;
  assign out_ch.left_compare    = lcmp_r;
  assign out_ch.right_compare   = rcmp_r;
  assign out_ch.heading_forward = fwd_r;
  assign out_ch.stored_speed    = spd_r;

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    prod_nxt   = prod_r;
    quot_nxt   = quot_r;
    bridge_nxt = bridge_r;
    lcmp_nxt   = lcmp_r;
    rcmp_nxt   = rcmp_r;
    fwd_nxt    = fwd_r;
    spd_nxt    = spd_r;
    take       = 1'b0;
    case (state_r)
      ST_IDLE, ST_WAIT: begin
        if (state_r == ST_WAIT && out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
        take = (state_r == ST_IDLE) || out_ch.ready;
        if (take && q_valid) begin
          cmd_nxt   = q_data;
          state_nxt = (q_data.kind == KIND_MIX) ? ST_MUL : ST_APPLY;
        end
      end
      ST_MUL: begin
        prod_nxt  = 14'(cmd_r.mag) * 14'(cmd_r.steer_mag);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        quot_nxt  = q_full[RECIP_SHIFT+6:RECIP_SHIFT];
        state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        spd_nxt    = cmd_r.speed;
        fwd_nxt    = cmd_r.fwd;
        bridge_nxt = cmd_r.bits;
        if (cmd_r.kind == KIND_MIX) begin
          if (left_side < SIDE_MIN) begin
            bridge_nxt[1:0] = 2'b00;
          end
          if (right_side < SIDE_MIN) begin
            bridge_nxt[3:2] = 2'b00;
          end
          lcmp_nxt = side_compare(left_side);
          rcmp_nxt = side_compare(right_side);
        end
        state_nxt = ST_WAIT;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign q_ready = take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      bridge_r <= BITS_OFF;
      lcmp_r   <= CMP_MIN;
      rcmp_r   <= CMP_MIN;
      fwd_r    <= 1'b0;
      spd_r    <= 8'sd0;
    end else begin
      state_r  <= state_nxt;
      bridge_r <= bridge_nxt;
      lcmp_r   <= lcmp_nxt;
      rcmp_r   <= rcmp_nxt;
      fwd_r    <= fwd_nxt;
      spd_r    <= spd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    prod_r <= prod_nxt;
    quot_r <= quot_nxt;
  end

`ifndef SYNTHESIS
  a_no_shoot_through: assert property (@(posedge clk) disable iff (!rst_n)
    !(bridge_r[0] && bridge_r[1]) && !(bridge_r[2] && bridge_r[3]))
    else $error("bridge drives both directions on one side");

  a_compare_range: assert property (@(posedge clk) disable iff (!rst_n)
    (lcmp_r >= CMP_MIN) && (lcmp_r <= CMP_LIMIT) && (rcmp_r >= CMP_MIN) && (rcmp_r <= CMP_LIMIT))
    else $error("compare value out of range");

  a_pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && q_ready) |-> ((state_r == ST_IDLE) || (state_r == ST_WAIT && out_ch.ready)))
    else $error("request taken while busy");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(bridge_r) && $stable(lcmp_r)))
    else $error("result changed while waiting");
`endif

endmodule

[rtl/core/differential_drive_mixer_top.sv]
// A mixing request passes through the back end's multiply, reciprocal divide and apply steps
// before its result is offered; a request that holds the compare values (deadband, obstacle
// ahead, binary mode) goes straight to apply. The back end works on one request at a time and
// pops another only when idle or when its result is accepted; a 2-entry queue decouples the input.
// Reset (rst_n low, synchronous): compare values 1000, direction bits, heading and stored
// speed zero, proportional mode, queue empty.
module differential_drive_mixer_top (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  ddm_in_if.sink    in_ch,
  ddm_out_if.source out_ch
);
  import ddm_pkg::*;

  logic mode_r;
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;
  cmd_t q_data;
  logic q_valid;
  logic q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  ddm_front u_front (
    .in_ch     (in_ch),
    .mode      (mode_r),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready)
  );

  ddm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_data  (cmd),
    .push_valid (cmd_valid),
    .push_ready (cmd_ready),
    .pop_data   (q_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready)
  );

  ddm_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_data  (q_data),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .out_ch  (out_ch)
  );

endmodule

[tb/ddm_checker.sv]
module ddm_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  ddm_in_if           in_ch,
  ddm_out_if          out_ch,
  output int unsigned fail_count,
  output int unsigned pending_count,
  output int unsigned result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import ddm_pkg::*;

  localparam int PERCENT = 100;

  typedef struct packed {
    logic [3:0]        bits;
    logic [11:0]       left_cmp;
    logic [11:0]       right_cmp;
    logic              fwd;
    logic signed [7:0] speed;
  } drive_result_t;

  drive_result_t     drive_expect_q[$];
  logic              binary_mode;
  logic [11:0]       left_cmp_hold;
  logic [11:0]       right_cmp_hold;
  logic signed [7:0] speed_hold;
  logic              heading;
  logic [3:0]        bridge;

  function automatic int clamp_cmd(int v);
    if (v < -int'(CMD_LIMIT)) return -int'(CMD_LIMIT);
    if (v > int'(CMD_LIMIT)) return int'(CMD_LIMIT);
    return v;
  endfunction

  function automatic logic [11:0] side_compare(int side);
    int c;
    c = int'(CMP_MIN) + int'(CMP_STEP) * side;
    if (c >= int'(CMP_LIMIT)) c = int'(CMP_LIMIT);
    return 12'(c);
  endfunction

  function automatic drive_result_t mix_drive(int spd, int str, logic obst);
    int            band;
    int            mag;
    int            lft;
    int            rgt;
    drive_result_t r;
    band = int'(DEAD_BAND);
    if (!binary_mode) begin
      spd = clamp_cmd(spd);
      str = clamp_cmd(str);
    end
    speed_hold = 8'(spd);
    if (spd > -band && spd < band) begin
      heading = 1'b0;
      bridge  = BITS_OFF;
    end else if (spd > 0 && obst) begin
      heading = 1'b1;
      bridge  = BITS_OFF;
    end else if (binary_mode) begin
      heading = (spd > 0);
      if (str < -band) begin
        bridge = (spd > 0) ? BITS_SPIN_L : BITS_SPIN_R;
      end else if (str > band) begin
        bridge = (spd > 0) ? BITS_SPIN_R : BITS_SPIN_L;
      end else begin
        bridge = (spd > 0) ? BITS_FWD : BITS_REV;
      end
    end else begin
      heading = (spd > 0);
      mag     = (spd < 0) ? -spd : spd;
      bridge  = (spd < 0) ? BITS_REV : BITS_FWD;
      lft     = mag;
      rgt     = mag;
      // scale down the inner side by the steer amount
      if (str < 0) lft = lft - (lft * -str) / PERCENT;
      else rgt = rgt - (rgt * str) / PERCENT;
      if (lft < int'(SIDE_MIN)) bridge[1:0] = 2'b00;
      if (rgt < int'(SIDE_MIN)) bridge[3:2] = 2'b00;
      left_cmp_hold  = side_compare(lft);
      right_cmp_hold = side_compare(rgt);
    end
    r.bits      = bridge;
    r.left_cmp  = left_cmp_hold;
    r.right_cmp = right_cmp_hold;
    r.fwd       = heading;
    r.speed     = speed_hold;
    return r;
  endfunction

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    drive_result_t want;
    if (!rst_n) begin
      binary_mode    = 1'b0;
      left_cmp_hold  = CMP_MIN;
      right_cmp_hold = CMP_MIN;
      speed_hold     = '0;
      heading        = 1'b0;
      bridge         = BITS_OFF;
      fail_count     = 0;
      result_count   = 0;
      drive_expect_q.delete();
    end else begin
      if (cfg_wr_en) binary_mode = cfg_wr_data;
      if (in_ch.valid && in_ch.ready) begin
        drive_expect_q.push_back(mix_drive(int'(in_ch.speed), int'(in_ch.steer),
                                           in_ch.obstacle_near));
      end
      if (out_ch.valid && out_ch.ready) begin
        result_count++;
        if (drive_expect_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got bits %h left %0d right %0d",
                   $time, out_ch.direction_bits, out_ch.left_compare, out_ch.right_compare);
          fail_count++;
        end else begin
          want = drive_expect_q.pop_front();
          check_field("direction_bits", int'(want.bits), int'(out_ch.direction_bits));
          check_field("left_compare", int'(want.left_cmp), int'(out_ch.left_compare));
          check_field("right_compare", int'(want.right_cmp), int'(out_ch.right_compare));
          check_field("heading_forward", int'(want.fwd), int'(out_ch.heading_forward));
          check_field("stored_speed", int'($signed(want.speed)),
                      int'($signed(out_ch.stored_speed)));
        end
      end
    end
    pending_count <= drive_expect_q.size();
  end

endmodule

[tb/differential_drive_mixer_top_test.sv]
module differential_drive_mixer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ddm_pkg::*;

  localparam logic MODE_PROPORTIONAL = 1'b0;
  localparam logic MODE_BINARY       = 1'b1;
  localparam int   RANDOM_PHASES     = 5;
  localparam int   PHASE_REQUESTS    = 100;
  localparam int   SETTLE_CYCLES     = 8;
  localparam int   CYCLE_LIMIT       = 200000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned result_count;
  int unsigned cycle_count = 0;
  int          sent_count = 0;
  int          directed_count = 0;
  int          mode_writes = 0;
  int          in_run_left = 0;
  bit          in_quiet = 1'b0;
  int          out_run_left = 0;
  bit          out_quiet = 1'b0;

  ddm_in_if  in_ch ();
  ddm_out_if out_ch ();

  differential_drive_mixer_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  ddm_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .result_count  (result_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d requests outstanding",
               cycle_count, pending_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // alternate runs of busy traffic with runs of random gaps
  function automatic int draw_wait(inout int run_left, inout bit quiet);
    if (run_left == 0) begin
      quiet    = ($urandom_range(0, 3) == 0);
      run_left = $urandom_range(8, 40);
    end
    run_left--;
    return quiet ? 0 : int'($urandom_range(0, 8));
  endfunction

  function automatic int pick_command();
    case ($urandom_range(0, 5))
      0, 1: return int'($urandom_range(0, 255)) - 128;
      2: return int'($urandom_range(0, 24)) - 12;
      3: begin
        case ($urandom_range(0, 7))
          0: return -128;
          1: return 127;
          2: return -101;
          3: return 101;
          4: return 100;
          5: return -100;
          6: return -11;
          default: return 11;
        endcase
      end
      default: return int'($urandom_range(0, 200)) - 100;
    endcase
  endfunction

  task automatic send_request(input int spd, input int str, input logic obst);
    int gap;
    gap = draw_wait(in_run_left, in_quiet);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.speed         <= 8'(spd);
    in_ch.steer         <= 8'(str);
    in_ch.obstacle_near <= obst;
    do @(posedge clk); while (!in_ch.ready);
    sent_count++;
  endtask

  task automatic drain_requests();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  task automatic set_mode(input logic mode);
    drain_requests();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mode_writes++;
  endtask

  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = draw_wait(out_run_left, out_quiet);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin
    rst_n               <= 1'b0;
    cfg_wr_en           <= 1'b0;
    cfg_wr_data         <= MODE_PROPORTIONAL;
    in_ch.valid         <= 1'b0;
    in_ch.speed         <= '0;
    in_ch.steer         <= '0;
    in_ch.obstacle_near <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    set_mode(MODE_PROPORTIONAL);
    send_request(0, 0, 1'b0);
    send_request(9, -128, 1'b1);
    send_request(-9, 127, 1'b0);
    send_request(10, 0, 1'b0);
    send_request(-10, 0, 1'b1);
    send_request(127, 127, 1'b0);
    send_request(-128, -128, 1'b1);
    send_request(100, 0, 1'b1);
    send_request(50, -50, 1'b0);
    send_request(20, 60, 1'b0);
    send_request(-20, -60, 1'b0);
    send_request(100, -1, 1'b0);
    send_request(-101, 101, 1'b0);

    set_mode(MODE_BINARY);
    send_request(127, 127, 1'b0);
    send_request(127, -128, 1'b0);
    send_request(10, 10, 1'b0);
    send_request(10, 11, 1'b0);
    send_request(-10, -11, 1'b0);
    send_request(-128, 11, 1'b0);
    send_request(-10, -10, 1'b0);
    send_request(50, 0, 1'b1);
    send_request(5, 100, 1'b1);
    send_request(-50, -128, 1'b1);
    send_request(-9, 0, 1'b0);
    directed_count = sent_count;

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      set_mode((phase % 2 == 0) ? MODE_PROPORTIONAL : MODE_BINARY);
      for (int i = 0; i < PHASE_REQUESTS; i++) begin
        send_request(pick_command(), pick_command(), ($urandom_range(0, 2) == 0));
      end
    end

    drain_requests();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Drove %0d drive requests (%0d directed) over %0d mode writes in %0d cycles",
             sent_count, directed_count, mode_writes, cycle_count);
    $display("Checked %0d results in proportional and binary steering", result_count);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/ddm_pkg.sv
rtl/core/ddm_in_if.sv
rtl/core/ddm_out_if.sv
rtl/core/ddm_front.sv
rtl/core/ddm_queue.sv
rtl/core/ddm_back.sv
rtl/core/differential_drive_mixer_top.sv
tb/ddm_checker.sv
tb/differential_drive_mixer_top_test.sv
